// ===== sv/crn_pkg.sv =====
// Package for the cube root unit: sequencer states, register indexes, defaults.
package crn_pkg;

	localparam int DataWidthDef = 32;
	localparam int FracBitsDef  = 16;

	localparam int CfgIndexW = 2;
	localparam int CfgDataW  = 16;

	localparam logic [CfgIndexW-1:0] RegIterLimit = 2'd0;
	localparam logic [CfgIndexW-1:0] RegTolerance = 2'd1;
	localparam logic [CfgIndexW-1:0] RegStopOnTol = 2'd2;

	localparam logic [5:0]  IterLimitRst = 6'd10;
	localparam logic [15:0] ToleranceRst = 16'd1;
	localparam logic        StopOnTolRst = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL,
		ST_DIV,
		ST_DIV3,
		ST_UPDATE,
		ST_FIN
	} crn_state_t;

endpackage

// ===== sv/cube_root_newton.sv =====
// Cube root by Newton steps with a bit-serial multiplier and restoring dividers.
// A zero operand goes straight to the result; a step whose square rounds to zero skips both divides.
// W = DATA_WIDTH, F = FRAC_BITS; squaring, the W+F bit quotient and the divide by three
// take one bit per cycle. One item at a time; the next is taken once the result is registered.
// arst_n clears control state and loads iteration_limit 10, tolerance 1, stop_on_tolerance 1.
module cube_root_newton #(
	parameter int DATA_WIDTH = crn_pkg::DataWidthDef,
	parameter int FRAC_BITS  = crn_pkg::FracBitsDef
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [crn_pkg::CfgIndexW-1:0]    cfg_index,
	input  logic [crn_pkg::CfgDataW-1:0]     cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [DATA_WIDTH-1:0]     operand,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [DATA_WIDTH-1:0]     root,
	output logic [5:0]                       steps_used,
	output logic                             converged,
	output logic                             saturated
);
	import crn_pkg::*;

	localparam int W     = DATA_WIDTH;
	localparam int F     = FRAC_BITS;
	localparam int NW    = W + F;       // dividend width
	localparam int DW    = 2 * W - F;   // divisor (square) width
	localparam int CNT_W = $clog2(NW + 1);

	crn_state_t state_q, state_nx;

	logic [5:0]   limit_q;
	logic [15:0]  tol_q;
	logic         stop_q;

	logic         neg_q;
	logic [W-1:0] m_q, lim_q, y_q, ny_q;
	logic [5:0]   steps_q;
	logic         conv_q, sat_q;
	logic [CNT_W-1:0] cnt_q;

	logic [2*W-1:0] prod_q;
	logic [DW-1:0]  sq_q, rem_q;
	logic [NW-1:0]  num_q, quo_q;
	logic [W:0]     s_q, q3_q;
	logic [1:0]     r3_q;

	logic [W-1:0]   root_q;
	logic [5:0]     steps_out_q;
	logic           conv_out_q, sat_out_q, out_valid_q;

	logic in_acc, out_load;

	// datapath terms
	logic [W-1:0]   in_raw, in_mag;
	logic           in_neg;
	logic [W:0]     mul_sum;
	logic [2*W-1:0] prod_nx;
	logic [DW-1:0]  sq_nx;
	logic           sq_zero;
	logic [DW:0]    dv_t;
	logic           dv_ge;
	logic [NW-1:0]  quo_nx;
	logic           q_sat;
	logic [W-1:0]   qv;
	logic [W:0]     s_init;
	logic [2:0]     t3;
	logic           ge3;
	logic [W:0]     q3_nx;
	logic [W-1:0]   diff;
	logic           step_conv;
	logic           mul_last, div_last, div3_last;

	assign in_raw  = operand;
	assign in_neg  = in_raw[W-1];
	assign in_mag  = in_neg ? (~in_raw + W'(1)) : in_raw;

	assign mul_sum = {1'b0, prod_q[2*W-1:W]} + {1'b0, y_q};
	assign prod_nx = prod_q[0] ? {mul_sum, prod_q[W-1:1]} : {1'b0, prod_q[2*W-1:1]};
	assign sq_nx   = prod_nx[2*W-1:F];
	assign sq_zero = (sq_nx == '0);

	assign dv_t   = {rem_q, num_q[NW-1]};
	assign dv_ge  = (dv_t >= {1'b0, sq_q});
	assign quo_nx = {quo_q[NW-2:0], dv_ge};
	assign q_sat  = (quo_nx > NW'(lim_q));
	assign qv     = q_sat ? lim_q : quo_nx[W-1:0];
	assign s_init = ({1'b0, y_q} << 1) + {1'b0, qv};

	assign t3    = {r3_q, s_q[W]};
	assign ge3   = (t3 >= 3'd3);
	assign q3_nx = {q3_q[W-1:0], ge3};

	assign diff      = (ny_q > y_q) ? (ny_q - y_q) : (y_q - ny_q);
	assign step_conv = (diff <= W'(tol_q));

	assign mul_last  = (cnt_q == CNT_W'(W - 1));
	assign div_last  = (cnt_q == CNT_W'(NW - 1));
	assign div3_last = (cnt_q == CNT_W'(W));

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_nx = (in_mag == '0) ? ST_FIN : ST_CHECK;
			end
			ST_CHECK:  state_nx = (steps_q >= limit_q) ? ST_FIN : ST_MUL;
			ST_MUL: begin
				if (mul_last)
					state_nx = sq_zero ? ST_UPDATE : ST_DIV;
			end
			ST_DIV:    if (div_last) state_nx = ST_DIV3;
			ST_DIV3:   if (div3_last) state_nx = ST_UPDATE;
			ST_UPDATE: state_nx = (stop_q && step_conv) ? ST_FIN : ST_CHECK;
			ST_FIN:    if (!out_valid_q || !out_stall) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		out_load = (state_q == ST_FIN) && (!out_valid_q || !out_stall);
	end

	assign in_acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			limit_q     <= IterLimitRst;
			tol_q       <= ToleranceRst;
			stop_q      <= StopOnTolRst;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_write) begin
				case (cfg_index)
					RegIterLimit: limit_q <= cfg_data[5:0];
					RegTolerance: tol_q   <= cfg_data;
					RegStopOnTol: stop_q  <= cfg_data[0];
					default: ;
				endcase
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					neg_q   <= in_neg;
					m_q     <= in_mag;
					lim_q   <= in_neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
					y_q     <= in_mag;
					steps_q <= '0;
					conv_q  <= (in_mag == '0);
					sat_q   <= 1'b0;
				end
			end
			ST_CHECK: begin
				prod_q <= {{W{1'b0}}, y_q};
				cnt_q  <= '0;
			end
			ST_MUL: begin
				prod_q <= prod_nx;
				cnt_q  <= cnt_q + CNT_W'(1);
				if (mul_last) begin
					sq_q  <= sq_nx;
					rem_q <= '0;
					num_q <= NW'(m_q) << F;
					quo_q <= '0;
					cnt_q <= '0;
					if (sq_zero) begin
						ny_q  <= lim_q;
						sat_q <= 1'b1;
					end
				end
			end
			ST_DIV: begin
				rem_q <= dv_ge ? DW'(dv_t - {1'b0, sq_q}) : dv_t[DW-1:0];
				num_q <= num_q << 1;
				quo_q <= quo_nx;
				cnt_q <= cnt_q + CNT_W'(1);
				if (div_last) begin
					if (q_sat) sat_q <= 1'b1;
					s_q   <= s_init;
					q3_q  <= '0;
					r3_q  <= '0;
					cnt_q <= '0;
				end
			end
			ST_DIV3: begin
				r3_q  <= ge3 ? 2'(t3 - 3'd3) : t3[1:0];
				s_q   <= s_q << 1;
				q3_q  <= q3_nx;
				cnt_q <= cnt_q + CNT_W'(1);
				if (div3_last) ny_q <= q3_nx[W-1:0];
			end
			ST_UPDATE: begin
				y_q     <= ny_q;
				steps_q <= steps_q + 6'd1;
				conv_q  <= step_conv;
			end
			default: ;
		endcase
		if (out_load) begin
			root_q      <= neg_q ? (~y_q + W'(1)) : y_q;
			steps_out_q <= steps_q;
			conv_out_q  <= conv_q;
			sat_out_q   <= sat_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign root       = root_q;
	assign steps_used = steps_out_q;
	assign converged  = conv_out_q;
	assign saturated  = sat_out_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("item accepted but unit not busy");

	a_steps_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (steps_q < limit_q))
		else $error("step taken beyond iteration limit");

	a_fin_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q && (state_q == ST_IDLE))
		else $error("result not registered");

	a_mul_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (cnt_q < CNT_W'(W)))
		else $error("multiplier count overrun");

endmodule
